// File: rtl/core/fbq_pkg.sv
// ----------------------------------------------------------------------------
// fbq_pkg
// Shared types and codes of the bounded FIFO queue: operation codes, result
// status codes, controller states and fixed field widths.
// ----------------------------------------------------------------------------
package fbq_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned LimitW = 5;
  localparam int unsigned CountW = 5;

  localparam logic [LimitW-1:0] LimitReset = 5'd16;

  typedef enum logic [1:0] {
    FN_ENQ  = 2'd0,
    FN_DEQ  = 2'd1,
    FN_DISP = 2'd2,
    FN_PEEK = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_OVF   = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_DISP
  } state_e;

endpackage

// File: rtl/core/fbq_store.sv
// ----------------------------------------------------------------------------
// fbq_store
// Ring store of the queue: one write port and two read ports with registered
// read data. Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module fbq_store #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(DEPTH)-1:0]     waddr_i,
  input  logic [fbq_pkg::DataW-1:0]    wdata_i,
  input  logic                         re_i,
  input  logic [$clog2(DEPTH)-1:0]     raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0]     raddr_b_i,
  output logic [fbq_pkg::DataW-1:0]    rdata_a_o,
  output logic [fbq_pkg::DataW-1:0]    rdata_b_o
);
  import fbq_pkg::*;

  logic [DataW-1:0] mem_q [DEPTH];
  logic [DataW-1:0] rdata_a_q;
  logic [DataW-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: rtl/core/fbq_ctrl.sv
// ----------------------------------------------------------------------------
// fbq_ctrl
// Queue controller: head and count registers, limit register, store access,
// display sequencer and the output stage that pairs the registered result
// flags with the registered store read data.
// ----------------------------------------------------------------------------
module fbq_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fbq_pkg::LimitW-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        func_i,
  input  logic signed [fbq_pkg::DataW-1:0]  item_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic signed [fbq_pkg::DataW-1:0]  front_value_o,
  output logic signed [fbq_pkg::DataW-1:0]  rear_value_o,
  output logic [fbq_pkg::CountW-1:0]        entry_count_o,
  output logic                              empty_flag_o,
  output logic                              full_flag_o,
  output logic                              last_o,
  output logic                              mem_we_o,
  output logic [$clog2(DEPTH)-1:0]          mem_waddr_o,
  output logic [fbq_pkg::DataW-1:0]         mem_wdata_o,
  output logic                              mem_re_o,
  output logic [$clog2(DEPTH)-1:0]          mem_raddr_a_o,
  output logic [$clog2(DEPTH)-1:0]          mem_raddr_b_o,
  input  logic [fbq_pkg::DataW-1:0]         mem_rdata_a_i,
  input  logic [fbq_pkg::DataW-1:0]         mem_rdata_b_i
);
  import fbq_pkg::*;

  localparam int unsigned IdxW    = $clog2(DEPTH);
  localparam int unsigned SumW    = IdxW + 1;
  localparam int unsigned MaxHeld = (DEPTH < 31) ? DEPTH : 31;
  localparam int unsigned CntW    = $clog2(MaxHeld + 1);

  function automatic logic [IdxW-1:0] wrap_idx(input logic [SumW-1:0] s);
    logic [SumW-1:0] r;
    r = s;
    if (s >= SumW'(DEPTH)) begin
      r = s - SumW'(DEPTH);
    end
    return r[IdxW-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [IdxW-1:0]   head_q, head_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   disp_q, disp_d;
  logic [LimitW-1:0] limit_q;
  logic [CntW-1:0]   eff_limit;

  logic              out_valid_q;
  status_e           status_q, status_d;
  logic [CntW-1:0]   cnt_out_q;
  logic              empty_q, full_q, last_q, last_d;
  logic              use_front_q, use_front_d;
  logic              use_rear_q, use_rear_d;

  logic              adv;
  logic              accept;
  logic              load;
  logic              is_full;
  logic              disp_last;
  logic [SumW-1:0]   rear_sum;

  // effective limit: zero acts as one, clamp at the smaller of store depth and 31
  always_comb begin
    eff_limit = CntW'(limit_q);
    if (limit_q == '0) begin
      eff_limit = CntW'(1);
    end else if (int'(limit_q) > MaxHeld) begin
      eff_limit = CntW'(MaxHeld);
    end
  end

  assign is_full    = (cnt_q >= eff_limit);
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && adv;
  assign accept     = in_valid_i && in_ready_o;
  assign disp_last  = ((disp_q + CntW'(1)) == cnt_q);
  assign rear_sum   = SumW'(head_q) + SumW'(cnt_q) - SumW'(1);

  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    cnt_d         = cnt_q;
    disp_d        = disp_q;
    load          = 1'b0;
    status_d      = STAT_OK;
    last_d        = 1'b1;
    use_front_d   = 1'b0;
    use_rear_d    = 1'b0;
    mem_we_o      = 1'b0;
    mem_waddr_o   = wrap_idx(SumW'(head_q) + SumW'(cnt_q));
    mem_wdata_o   = item_value_i;
    mem_re_o      = 1'b0;
    mem_raddr_a_o = head_q;
    mem_raddr_b_o = wrap_idx(rear_sum);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          load = 1'b1;
          unique case (func_e'(func_i))
            FN_ENQ: begin
              if (is_full) begin
                status_d = STAT_OVF;
              end else begin
                mem_we_o = 1'b1;
                cnt_d    = cnt_q + CntW'(1);
              end
            end
            FN_DEQ: begin
              if (cnt_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                mem_re_o    = 1'b1;
                use_front_d = 1'b1;
                head_d      = wrap_idx(SumW'(head_q) + SumW'(1));
                cnt_d       = cnt_q - CntW'(1);
              end
            end
            FN_DISP: begin
              if (cnt_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                mem_re_o    = 1'b1;
                use_front_d = 1'b1;
                last_d      = (cnt_q == CntW'(1));
                disp_d      = CntW'(1);
                if (cnt_q != CntW'(1)) begin
                  state_d = ST_DISP;
                end
              end
            end
            FN_PEEK: begin
              if (cnt_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                mem_re_o    = 1'b1;
                use_front_d = 1'b1;
                use_rear_d  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DISP: begin
        // stream one stored word per free output slot
        mem_raddr_a_o = wrap_idx(SumW'(head_q) + SumW'(disp_q));
        if (adv) begin
          load        = 1'b1;
          mem_re_o    = 1'b1;
          use_front_d = 1'b1;
          last_d      = disp_last;
          disp_d      = disp_q + CntW'(1);
          if (disp_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      disp_q      <= '0;
      limit_q     <= LimitReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      disp_q  <= disp_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q    <= status_d;
      cnt_out_q   <= cnt_d;
      empty_q     <= (cnt_d == '0);
      full_q      <= (cnt_d >= eff_limit);
      last_q      <= last_d;
      use_front_q <= use_front_d;
      use_rear_q  <= use_rear_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign front_value_o = use_front_q ? $signed(mem_rdata_a_i) : '0;
  assign rear_value_o  = use_rear_q ? $signed(mem_rdata_b_i) : '0;
  assign entry_count_o = CountW'(cnt_out_q);
  assign empty_flag_o  = empty_q;
  assign full_flag_o   = full_q;
  assign last_o        = last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxHeld))
    else $error("entry count beyond store capacity");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(head_q) < DEPTH)
    else $error("head index outside ring");

  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (func_i == FN_ENQ) && !is_full) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("enqueue did not advance count");

  a_disp_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DISP && adv && disp_last) |=> (state_q == ST_IDLE && out_valid_q && last_q))
    else $error("display stream did not close");

  a_disp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DISP) |=> $stable(cnt_q) && $stable(head_q))
    else $error("queue state changed during display");

endmodule

// File: rtl/core/bounded_fifo_queue_core.sv
// ----------------------------------------------------------------------------
// bounded_fifo_queue_core
// Bounded FIFO of signed 32-bit words in a ring store, with enqueue, dequeue,
// peek and display operations and a programmable capacity.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries func_i and item_value_i.
//   Output channel (out_valid_o/out_ready_i) carries one result word per
//   result; last_o marks the final word of an operation.
//   cfg_we_i/cfg_wdata_i write the capacity limit; write only while idle.
//   Output: a result appears in the cycle after its operation is taken, since
//   the store read data is registered.
//   Throughput: enqueue, dequeue and peek need no busy state. Display of N
//   held words streams N results at one per cycle while out_ready_i is high
//   and holds in_ready_o low until the last word has been issued.
//   A stalled receiver holds the result in the output stage; the input side
//   stops taking words until that stage frees.
//   Reset clears the queue to empty and sets the limit to 16. The store
//   needs no clearing pass: an entry is read only after it was written.
// ----------------------------------------------------------------------------
module bounded_fifo_queue_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fbq_pkg::LimitW-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        func_i,
  input  logic signed [fbq_pkg::DataW-1:0]  item_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic signed [fbq_pkg::DataW-1:0]  front_value_o,
  output logic signed [fbq_pkg::DataW-1:0]  rear_value_o,
  output logic [fbq_pkg::CountW-1:0]        entry_count_o,
  output logic                              empty_flag_o,
  output logic                              full_flag_o,
  output logic                              last_o
);
  import fbq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);

  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic             mem_re;
  logic [IdxW-1:0]  mem_raddr_a;
  logic [IdxW-1:0]  mem_raddr_b;
  logic [DataW-1:0] mem_rdata_a;
  logic [DataW-1:0] mem_rdata_b;

  fbq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .item_value_i  (item_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .front_value_o (front_value_o),
    .rear_value_o  (rear_value_o),
    .entry_count_o (entry_count_o),
    .empty_flag_o  (empty_flag_o),
    .full_flag_o   (full_flag_o),
    .last_o        (last_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b)
  );

  fbq_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (mem_re),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

endmodule
